[sv/gfa_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, widths and coefficient table for the gamma function approximation.
// No dependencies.
package gfa_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int CFRAC       = 30;
    localparam int MAX_ARG     = 12;
    localparam int ARG_W       = 20;
    localparam int VAL_W       = 48;
    localparam int IN_TDATA_W  = ((ARG_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;

    localparam int HALF_W  = 22;
    localparam int MA_W    = 2 * HALF_W;
    localparam int MB_W    = 33;
    localparam int PP_W    = HALF_W + MB_W;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int RND_W   = PROD_W - FRAC_BITS;
    localparam int NUM_W   = 44;
    localparam int DEN_W   = FRAC_BITS + 2;
    localparam int U_W     = FRAC_BITS + 1;
    localparam int S_W     = MB_W + 1;
    localparam int DIVN_W  = DEN_W + FRAC_BITS;
    localparam int CNT_W   = $clog2(DIVN_W);
    localparam int NCOEF   = 11;
    localparam int IDX_W   = $clog2(NCOEF + 1);

    localparam logic [ARG_W-1:0]  ONE    = ARG_W'(1) << FRAC_BITS;
    localparam logic [ARG_W-1:0]  X_MAX  = ARG_W'(MAX_ARG) << FRAC_BITS;
    localparam logic [DEN_W-1:0]  DEN_ONE = DEN_W'(1) << FRAC_BITS;
    localparam logic [NUM_W-1:0]  NUM_ONE = NUM_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] RND16  = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] RND30  = PROD_W'(1) << (CFRAC - 1);

    typedef enum logic [3:0] {
        OP_DEN  = 4'b0001,
        OP_NUM  = 4'b0010,
        OP_HORN = 4'b0100,
        OP_FIN  = 4'b1000
    } t_mop;

    // Horner coefficients in Q2.30, highest degree first
    function automatic logic signed [31:0] coef(input logic [IDX_W-1:0] idx);
        logic signed [31:0] c;
        case (idx)
            IDX_W'(0):  c = 32'sd72704;
            IDX_W'(1):  c = -32'sd369619;
            IDX_W'(2):  c = 32'sd1653313;
            IDX_W'(3):  c = -32'sd2627176;
            IDX_W'(4):  c = 32'sd11782916;
            IDX_W'(5):  c = -32'sd226460;
            IDX_W'(6):  c = 32'sd79712346;
            IDX_W'(7):  c = 32'sd87593945;
            IDX_W'(8):  c = 32'sd442210103;
            IDX_W'(9):  c = 32'sd453961225;
            IDX_W'(10): c = 32'sd1073741824;
            default:    c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage

[sv/gamma_function_approx.sv]
`timescale 1ns / 1ps
// Gamma function approximation: argument reduction, Horner polynomial and final division
// on one shared multiplier and a bit-serial divider. Depends on gfa_pkg.
//
// Usage: the slave channel takes one item, the argument x (unsigned, 16 fraction bits) in
// tdata[19:0]. The master channel returns Gamma(x) in tdata[47:0] (16 fraction bits) and a
// domain error flag in tuser, set with a zero value when x is zero. Arguments above 12 are
// clamped to 12. One result is returned for every item, in order.
// A zero argument goes straight to the result register. For x above 2 there are
// k = ceil(x) - 3 reduction multiplies before the Horner steps and no divide; for
// 1 < x <= 2 and for x up to 1 the result ends with a bit-serial divide, which is
// skipped, for x up to 1, when x(x+1) rounds to exactly 1.
// The shared 22x33 multiplier runs S_MUL_A to S_MUL_D (two partial products, an add
// and a rounding shift) and sets the pace; the block takes one item at a time.
// The slave tready is high only while the sequencer is idle. A finished result sits in the
// output register while the next item is accepted and computed; if the receiver still
// stalls when that next result is done, the sequencer holds it until the register frees.
// Synchronous active-low reset empties the output register and returns the sequencer to
// idle; no clearing pass is needed.
module gamma_function_approx (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [gfa_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [19:0] arg, rest zero
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [gfa_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // [47:0] value
    output logic                           o_m_axis_tuser   // [0] domain_error
);
    import gfa_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_RED    = 10'b00_0000_0010,
        S_HSTART = 10'b00_0000_0100,
        S_HSTEP  = 10'b00_0000_1000,
        S_MUL_A  = 10'b00_0001_0000,
        S_MUL_B  = 10'b00_0010_0000,
        S_MUL_C  = 10'b00_0100_0000,
        S_MUL_D  = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    t_mop                      r_op, n_op;
    logic                      r_sh30, n_sh30;
    logic [ARG_W-1:0]          r_y, n_y;
    logic [U_W-1:0]            r_u, n_u;
    logic [NUM_W-1:0]          r_num, n_num;
    logic [DEN_W-1:0]          r_den, n_den;
    logic signed [S_W-1:0]     r_s, n_s;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [MA_W-1:0]           r_ma, n_ma;
    logic [MB_W-1:0]           r_mb, n_mb;
    logic [PP_W-1:0]           r_pp, n_pp;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [DIVN_W-1:0]         r_dq, n_dq;
    logic [DEN_W-1:0]          r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [VAL_W-1:0]          r_res_val, n_res_val;
    logic                      r_res_err, n_res_err;
    logic                      r_ovalid, n_ovalid;
    logic [VAL_W-1:0]          r_oval, n_oval;
    logic                      r_oerr, n_oerr;

    logic [ARG_W-1:0]          arg_in;
    logic [ARG_W-1:0]          x_clamp;
    logic                      in_accept;
    logic [HALF_W-1:0]         mul_half;
    logic [PP_W-1:0]           mul_pp;
    logic [PROD_W-1:0]         rnd_sum;
    logic [RND_W-1:0]          rnd;
    logic [MB_W-1:0]           s_mag;
    logic [MB_W-1:0]           s_pos;
    logic signed [S_W-1:0]     c_ext;
    logic signed [S_W-1:0]     m_ext;
    logic [VAL_W-1:0]          p_val;
    logic [DEN_W:0]            div_t;
    logic [DEN_W:0]            div_diff;
    logic                      div_ge;
    logic [DIVN_W-1:0]         div_q;
    logic                      out_free;

    assign arg_in    = i_s_axis_tdata[ARG_W-1:0];
    assign x_clamp   = (arg_in > X_MAX) ? X_MAX : arg_in;
    assign in_accept = i_s_axis_tvalid && (r_state == S_IDLE);

    assign mul_half = (r_state == S_MUL_A) ? r_ma[HALF_W-1:0] : r_ma[MA_W-1:HALF_W];
    assign mul_pp   = PP_W'(mul_half) * PP_W'(r_mb);
    assign rnd_sum  = r_prod + (r_sh30 ? RND30 : RND16);
    assign rnd      = r_sh30 ? RND_W'(rnd_sum >> CFRAC) : RND_W'(rnd_sum >> FRAC_BITS);

    assign s_mag = r_s[S_W-1] ? MB_W'(-r_s) : MB_W'(r_s);
    assign s_pos = r_s[S_W-1] ? '0 : MB_W'(r_s);
    assign c_ext = S_W'(coef(r_idx));
    assign m_ext = signed'({1'b0, rnd[MB_W-1:0]});
    assign p_val = (|rnd[RND_W-1:VAL_W]) ? '1 : rnd[VAL_W-1:0];

    assign div_t    = {r_rem, r_dq[DIVN_W-1]};
    assign div_ge   = div_t >= {1'b0, r_den};
    assign div_diff = div_t - {1'b0, r_den};
    assign div_q    = {r_dq[DIVN_W-2:0], div_ge};

    assign out_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_sh30    = r_sh30;
        n_y       = r_y;
        n_u       = r_u;
        n_num     = r_num;
        n_den     = r_den;
        n_s       = r_s;
        n_idx     = r_idx;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_pp      = r_pp;
        n_prod    = r_prod;
        n_dq      = r_dq;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_res_val = r_res_val;
        n_res_err = r_res_err;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_num = NUM_ONE;
                    n_den = DEN_ONE;
                    n_sh30 = 1'b0;
                    if (arg_in == '0) begin
                        n_res_val = '0;
                        n_res_err = 1'b1;
                        n_state   = S_DONE;
                    end else if (x_clamp <= ONE) begin
                        n_y     = x_clamp + (ONE << 1);
                        n_ma    = MA_W'(x_clamp);
                        n_mb    = MB_W'(x_clamp) + MB_W'(ONE);
                        n_op    = OP_DEN;
                        n_state = S_MUL_A;
                    end else if (x_clamp <= (ONE << 1)) begin
                        n_den   = DEN_W'(x_clamp);
                        n_y     = x_clamp + ONE;
                        n_state = S_HSTART;
                    end else begin
                        n_y     = x_clamp;
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (r_y > ARG_W'(3) * ONE) begin
                    n_y     = r_y - ONE;
                    n_ma    = r_num;
                    n_mb    = MB_W'(r_y - ONE);
                    n_op    = OP_NUM;
                    n_sh30  = 1'b0;
                    n_state = S_MUL_A;
                end else begin
                    n_state = S_HSTART;
                end
            end
            S_HSTART: begin
                n_u     = U_W'(r_y - (ONE << 1));
                n_s     = S_W'(coef(IDX_W'(0)));
                n_idx   = IDX_W'(1);
                n_state = S_HSTEP;
            end
            S_HSTEP: begin
                if (r_idx < IDX_W'(NCOEF)) begin
                    n_ma   = MA_W'(r_u);
                    n_mb   = s_mag;
                    n_op   = OP_HORN;
                    n_sh30 = 1'b0;
                end else begin
                    n_ma   = r_num;
                    n_mb   = s_pos;
                    n_op   = OP_FIN;
                    n_sh30 = 1'b1;
                end
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                n_pp    = mul_pp;
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_prod  = PROD_W'(r_pp);
                n_pp    = mul_pp;
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                n_prod  = r_prod + (PROD_W'(r_pp) << HALF_W);
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                case (r_op)
                    OP_DEN: begin
                        n_den   = rnd[DEN_W-1:0];
                        n_state = S_HSTART;
                    end
                    OP_NUM: begin
                        n_num   = rnd[NUM_W-1:0];
                        n_state = S_RED;
                    end
                    OP_HORN: begin
                        n_s     = r_s[S_W-1] ? (c_ext - m_ext) : (c_ext + m_ext);
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_HSTEP;
                    end
                    OP_FIN: begin
                        if (r_den != DEN_ONE) begin
                            n_dq    = {rnd[DEN_W-1:0], FRAC_BITS'(0)}
                                      + DIVN_W'(r_den >> 1);
                            n_rem   = '0;
                            n_cnt   = CNT_W'(DIVN_W - 1);
                            n_state = S_DIV;
                        end else begin
                            n_res_val = p_val;
                            n_res_err = 1'b0;
                            n_state   = S_DONE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff[DEN_W-1:0] : div_t[DEN_W-1:0];
                n_dq  = div_q;
                if (r_cnt == '0) begin
                    n_res_val = VAL_W'(div_q);
                    n_res_err = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_oerr   = r_oerr;
        if (r_state == S_DONE && out_free) begin
            n_ovalid = 1'b1;
            n_oval   = r_res_val;
            n_oerr   = r_res_err;
        end else if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_DEN;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh30    <= n_sh30;
        r_y       <= n_y;
        r_u       <= n_u;
        r_num     <= n_num;
        r_den     <= n_den;
        r_s       <= n_s;
        r_idx     <= n_idx;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_pp      <= n_pp;
        r_prod    <= n_prod;
        r_dq      <= n_dq;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_res_val <= n_res_val;
        r_res_err <= n_res_err;
        r_oval    <= n_oval;
        r_oerr    <= n_oerr;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_oval);
    assign o_m_axis_tuser  = r_oerr;

`ifndef SYNTHESIS
    a_zero_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && arg_in == '0) |=> (r_state == S_DONE && r_res_err))
        else $error("zero argument did not take the error path");

    a_reduced_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HSTART) |-> (r_y > (ONE << 1) && r_y <= ARG_W'(3) * ONE))
        else $error("reduced argument outside (2,3]");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("division by zero denominator");

    a_mul_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_A) |=> (r_state == S_MUL_B))
        else $error("multiply sequence broken");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("domain error with nonzero value");
`endif

endmodule

[test/tb_gamma_function_approx.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gamma_function_approx: a directed table, then random arguments,
// each result compared against a bit-exact Gamma(x) predictor under random source/sink pacing.
// Depends on gfa_pkg and gamma_function_approx.
module tb_gamma_function_approx;
    import gfa_pkg::*;

    localparam int          IDLE_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 120;
    localparam int          RANDOM_ITEMS = 1400;
    localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;
    localparam int          UNIT_I = 1 << FRAC_BITS;
    localparam logic [63:0] SAT_LIM = 64'd1 << 62;
    localparam logic [63:0] VAL_MAX = (64'd1 << VAL_W) - 64'd1;
    localparam int          ARG_TOP = MAX_ARG << FRAC_BITS;

    // polynomial coefficients scaled by 1e10, highest degree first; the constant 1.0 comes from horner_q30
    localparam longint COEF_E10 [10] = '{
        64'sd677106, -64'sd3442342, 64'sd15397681, -64'sd24467480, 64'sd109736958,
        -64'sd2109075, 64'sd742379071, 64'sd815782188, 64'sd4118402518, 64'sd4227843370
    };

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             err;
    } t_gamma_res;

    typedef struct packed {
        logic [ARG_W-1:0] arg;
        logic             typed;
        logic [VAL_W-1:0] value;
        logic             err;
    } t_arg_row;

    typedef enum logic [1:0] {RX_OPEN, RX_JITTER, RX_SLOW, RX_LONG} t_rx_mode;

    localparam t_arg_row DIRECTED [22] = '{
        '{20'h00000, 1'b1, 48'd0, 1'b1},
        '{20'h00001, 1'b0, 48'd0, 1'b0},
        '{20'h00002, 1'b0, 48'd0, 1'b0},
        '{20'h0FFFF, 1'b0, 48'd0, 1'b0},
        '{20'h10000, 1'b0, 48'd0, 1'b0},
        '{20'h10001, 1'b0, 48'd0, 1'b0},
        '{20'h18000, 1'b0, 48'd0, 1'b0},
        '{20'h1FFFF, 1'b0, 48'd0, 1'b0},
        '{20'h20000, 1'b0, 48'd0, 1'b0},
        '{20'h20001, 1'b0, 48'd0, 1'b0},
        '{20'h28000, 1'b0, 48'd0, 1'b0},
        '{20'h30000, 1'b0, 48'd0, 1'b0},
        '{20'h30001, 1'b0, 48'd0, 1'b0},
        '{20'h55AAA, 1'b0, 48'd0, 1'b0},
        '{20'hA5555, 1'b0, 48'd0, 1'b0},
        '{20'hA0000, 1'b0, 48'd0, 1'b0},
        '{20'hBFFFF, 1'b0, 48'd0, 1'b0},
        '{20'hC0000, 1'b0, 48'd0, 1'b0},
        '{20'hC0001, 1'b0, 48'd0, 1'b0},
        '{20'hD5555, 1'b0, 48'd0, 1'b0},
        '{20'hFFFFF, 1'b0, 48'd0, 1'b0},
        '{20'h00000, 1'b1, 48'd0, 1'b1}
    };

    logic                   i_clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [19:0] arg
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [47:0] value
    logic                   m_tuser;        // [0] domain_error

    t_arg_row    arg_rows [$];
    t_gamma_res  gamma_due [$];
    int unsigned faults = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned rx_seg = 0;
    int unsigned rx_stall = 0;
    t_rx_mode    rx_mode = RX_OPEN;

    gamma_function_approx dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint horner_q30(input int k);
        longint mag;
        if (k == 10) return 64'sd1 << CFRAC;
        mag = (COEF_E10[k] < 0) ? -COEF_E10[k] : COEF_E10[k];
        mag = (mag * 64'sd1073741824 + 64'sd5000000000) / 64'sd10000000000;
        return (COEF_E10[k] < 0) ? -mag : mag;
    endfunction

    function automatic logic [63:0] mul_round_sat(input logic [63:0] a, input logic [63:0] b,
                                                  input int sh);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (sh > 0) prod = prod + (128'd1 << (sh - 1));
        prod = prod >> sh;
        if (prod[127:64] != 64'd0) return SAT_LIM;
        return (prod[63:0] > SAT_LIM) ? SAT_LIM : prod[63:0];
    endfunction

    function automatic t_gamma_res gamma_q16(input logic [ARG_W-1:0] arg);
        logic [63:0]  x, y, u, num, den, p, m;
        logic [127:0] wide;
        longint       s;
        int           k;
        t_gamma_res   r;
        x = 64'(arg);
        r.value = '0;
        r.err = 1'b1;
        if (x == 64'd0) return r;
        if (x > MAX_ARG * UNIT) x = MAX_ARG * UNIT;
        num = UNIT;
        den = UNIT;
        y = x;
        if (x <= UNIT) begin
            den = mul_round_sat(x, x + UNIT, FRAC_BITS);
            y = x + 2 * UNIT;
        end else if (x <= 2 * UNIT) begin
            den = x;
            y = x + UNIT;
        end else begin
            while (y > 3 * UNIT) begin
                y = y - UNIT;
                num = mul_round_sat(num, y, FRAC_BITS);
            end
        end
        u = y - 2 * UNIT;
        s = horner_q30(0);
        for (k = 1; k <= 10; k++) begin
            if (s < 0) begin
                m = mul_round_sat(64'(-s), u, FRAC_BITS);
                s = horner_q30(k) - longint'(m);
            end else begin
                m = mul_round_sat(64'(s), u, FRAC_BITS);
                s = horner_q30(k) + longint'(m);
            end
        end
        if (s < 0) s = 0;
        p = mul_round_sat(64'(s), num, CFRAC);
        if (den != UNIT) begin
            if (den == 64'd0 || den[63:62] != 2'd0) begin
                p = SAT_LIM;
            end else begin
                wide = (({64'd0, p} << FRAC_BITS) + {65'd0, den[63:1]}) / {64'd0, den};
                p = (wide > {64'd0, SAT_LIM}) ? SAT_LIM : wide[63:0];
            end
        end
        r.value = (p > VAL_MAX) ? VAL_MAX[VAL_W-1:0] : p[VAL_W-1:0];
        r.err = 1'b0;
        return r;
    endfunction

    function automatic logic [ARG_W-1:0] pick_arg();
        int a;
        case ($urandom_range(0, 9))
            0: a = $urandom_range(1, UNIT_I);
            1: a = $urandom_range(UNIT_I + 1, 2 * UNIT_I);
            2: a = $urandom_range(2 * UNIT_I + 1, 3 * UNIT_I);
            7: a = $urandom_range(1, 2 * MAX_ARG) * (UNIT_I / 2);
            8: begin
                a = $urandom_range(0, MAX_ARG) * UNIT_I + $urandom_range(0, 4) - 2;
                if (a < 0) a = 0;
                if (a > ARG_TOP) a = ARG_TOP;
            end
            9: a = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, ARG_TOP);
            default: a = $urandom_range(3 * UNIT_I + 1, ARG_TOP);
        endcase
        return ARG_W'(a);
    endfunction

    task automatic send_arg(input t_arg_row row);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        arg_rows.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(row.arg);
        do @(posedge i_clk); while (!s_tready);
    endtask

    always @(posedge i_clk) begin : rx_pace
        logic rdy;
        rdy = 1'b1;
        if (rx_seg == 0) begin
            rx_seg <= $urandom_range(200, 3000);
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end else begin
            rx_seg <= rx_seg - 1;
        end
        if (rx_stall != 0) begin
            rdy = 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            case (rx_mode)
                RX_JITTER: if ($urandom_range(0, 1) == 0) begin
                    rdy = 1'b0;
                    rx_stall <= $urandom_range(0, 3);
                end
                RX_SLOW: if ($urandom_range(0, 7) != 0) begin
                    rdy = 1'b0;
                    rx_stall <= $urandom_range(0, 12);
                end
                RX_LONG: if ($urandom_range(0, 19) == 0) begin
                    rdy = 1'b0;
                    rx_stall <= $urandom_range(20, 150);
                end
                default: ;
            endcase
        end
        m_tready <= rdy;
    end

    always @(posedge i_clk) begin : gamma_check
        t_arg_row   row;
        t_gamma_res want;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                row = arg_rows.pop_front();
                if (row.typed) begin
                    want.value = row.value;
                    want.err = row.err;
                end else begin
                    want = gamma_q16(s_tdata[ARG_W-1:0]);
                end
                gamma_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (gamma_due.size() == 0) begin
                    $error("result with no item pending: value %0d domain_error %0d",
                           m_tdata[VAL_W-1:0], m_tuser);
                    faults++;
                end else begin
                    want = gamma_due.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_tdata[VAL_W-1:0]);
                        faults++;
                    end
                    if (m_tuser !== want.err) begin
                        $error("domain_error: expected %0d, got %0d", want.err, m_tuser);
                        faults++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_arg_row row;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[n]) send_arg(DIRECTED[n]);
        repeat (RANDOM_ITEMS) begin
            row = '0;
            row.arg = pick_arg();
            send_arg(row);
        end
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (gamma_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (faults == 0 && gamma_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
sv/gfa_pkg.sv
sv/gamma_function_approx.sv
test/tb_gamma_function_approx.sv
